/* design/lsc_pkg.sv */
// Shared types and codes for the line sensor calibrate/classify block.
package lsc_pkg;

  // Request kinds carried in the input tuser field
  typedef enum logic [2:0] {
    REQ_WHITE     = 3'd0,
    REQ_END_WHITE = 3'd1,
    REQ_GREEN     = 3'd2,
    REQ_END_GREEN = 3'd3,
    REQ_CLASSIFY  = 3'd4
  } req_t;

  // Result status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NO_WHITE = 2'd1;
  localparam logic [1:0] STATUS_NOT_CAL  = 2'd2;

  // Fixed field widths of the stream items
  localparam int unsigned REQ_W     = 3;
  localparam int unsigned CHANNEL_W = 4;
  localparam int unsigned SAMPLE_W  = 12;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned BITS_W    = 16;
  // Wide enough to hold any channel count in the supported range
  localparam int unsigned CH_EXT_W  = 6;

  // Command from the control path to one sensor bank
  typedef struct packed {
    logic accum;
    logic end_white;
    logic end_green;
  } bank_cmd_t;

  // Per-item answer from one sensor bank for the addressed channel
  typedef struct packed {
    logic in_range;
    logic active;
  } bank_res_t;

endpackage

/* design/lsc_bank.sv */
// One sensor bank: per-channel sums, white/green/threshold levels and classify compare.
module lsc_bank #(
  parameter int unsigned CHANNELS         = 16,
  parameter int unsigned CAL_SAMPLES_LOG2 = 6,
  parameter int unsigned SAMPLE_BITS      = 12
) (
  input  logic                             clk,
  input  logic                             rst,
  input  lsc_pkg::bank_cmd_t               cmd,
  input  logic [lsc_pkg::CHANNEL_W-1:0]    channel,
  input  logic [SAMPLE_BITS-1:0]           sample_val,
  output lsc_pkg::bank_res_t               res
);

  localparam int unsigned SUM_W = SAMPLE_BITS + CAL_SAMPLES_LOG2;

  logic [SUM_W-1:0]       sum_q     [CHANNELS];
  logic [SAMPLE_BITS-1:0] white_lvl [CHANNELS];
  logic [SAMPLE_BITS-1:0] green_lvl [CHANNELS];
  logic [SAMPLE_BITS-1:0] thr_lvl   [CHANNELS];

  logic [lsc_pkg::CH_EXT_W-1:0] ch_ext;
  logic [CHANNELS-1:0]          sel;

  assign ch_ext = lsc_pkg::CH_EXT_W'(channel);

  // Per-channel lanes
  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    logic [SUM_W:0]         sum_add;
    logic [SAMPLE_BITS-1:0] avg;
    logic [SAMPLE_BITS:0]   mid_sum;

    assign sel[c]  = (ch_ext == lsc_pkg::CH_EXT_W'(c));
    assign sum_add = {1'b0, sum_q[c]} + (SUM_W + 1)'(sample_val);
    assign avg     = SAMPLE_BITS'(sum_q[c] >> CAL_SAMPLES_LOG2);
    assign mid_sum = {1'b0, white_lvl[c]} + {1'b0, avg};

    // Accumulate with saturation, clear on either end of calibration
    always_ff @(posedge clk) begin
      if (rst) begin
        sum_q[c] <= '0;
      end else if (cmd.end_white || cmd.end_green) begin
        sum_q[c] <= '0;
      end else if (cmd.accum && sel[c]) begin
        sum_q[c] <= sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
      end
    end

    // Capture levels at the end of each calibration phase
    always_ff @(posedge clk) begin
      if (cmd.end_white) begin
        white_lvl[c] <= avg;
      end
      if (cmd.end_green) begin
        green_lvl[c] <= avg;
        thr_lvl[c]   <= mid_sum[SAMPLE_BITS:1];
      end
    end
  end

  // Select the addressed channel and compare against its threshold
  always_comb begin
    logic [SAMPLE_BITS-1:0] w_sel;
    logic [SAMPLE_BITS-1:0] g_sel;
    logic [SAMPLE_BITS-1:0] t_sel;
    w_sel = '0;
    g_sel = '0;
    t_sel = '0;
    for (int unsigned c = 0; c < CHANNELS; c++) begin
      if (sel[c]) begin
        w_sel = w_sel | white_lvl[c];
        g_sel = g_sel | green_lvl[c];
        t_sel = t_sel | thr_lvl[c];
      end
    end
    res.in_range = (ch_ext < lsc_pkg::CH_EXT_W'(CHANNELS));
    res.active   = (g_sel > w_sel) ? (sample_val < t_sel) : (sample_val > t_sel);
  end

endmodule

/* design/line_sensor_calibrate_classify.sv */
// Top level of the two-bank line sensor calibrate and classify block.
//
// Usage: items arrive on the s_axis channel. tuser carries the request kind
// (white sample, end white, green sample, end green, classify) and the bank;
// tdata carries the channel and the averaged converter reading. Every item
// produces exactly one result item on m_axis: a status code in tuser and the
// active bits and calibrated flags of both banks, as they stand after the
// item, in tdata.
// An accepted item passes through one input register and then one result register,
// with all per-item work in the single stage between them.
// Throughput is one item per clock while m_axis does not stall; the bank state is read and written
// only in that stage, so back-to-back items see each other's updates.
// When the receiver stalls, the result register holds and the input register
// can still take one more item; s_axis_tready then drops until m_axis moves.
// Synchronous reset clears sums, flags and active bits and empties both
// registers; calibration levels are not valid until the phases run again.
module line_sensor_calibrate_classify #(
  parameter int unsigned CHANNELS         = 16,
  parameter int unsigned CAL_SAMPLES_LOG2 = 6,
  parameter int unsigned SAMPLE_BITS      = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [3:0] channel, [15:4] sample
  input  logic [15:0] s_axis_tdata,
  // [2:0] req_type, [3] side
  input  logic [3:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] right_bits, [31:16] left_bits, [32] right_ready, [33] left_ready
  output logic [39:0] m_axis_tdata,
  // [1:0] status
  output logic [1:0]  m_axis_tuser
);

  // Input register
  logic                            s1_valid;
  logic [lsc_pkg::REQ_W-1:0]       s1_req;
  logic                            s1_side;
  logic [lsc_pkg::CHANNEL_W-1:0]   s1_channel;
  logic [lsc_pkg::SAMPLE_W-1:0]    s1_sample;

  logic adv;
  logic out_free;

  // Bank control state
  logic [1:0]                   white_done;
  logic [1:0]                   cal;
  logic [lsc_pkg::BITS_W-1:0]   active [2];

  logic [1:0]                   white_done_next;
  logic [1:0]                   cal_next;
  logic [lsc_pkg::BITS_W-1:0]   active_next [2];
  logic [lsc_pkg::STATUS_W-1:0] status_next;

  lsc_pkg::bank_cmd_t           bank_cmd [2];
  lsc_pkg::bank_res_t           bank_res [2];
  logic [SAMPLE_BITS-1:0]       sample_val;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign adv           = s1_valid && out_free;
  assign s_axis_tready = !s1_valid || out_free;
  assign sample_val    = SAMPLE_BITS'(s1_sample);

  // Capture accepted items
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_req     <= s_axis_tuser[2:0];
      s1_side    <= s_axis_tuser[3];
      s1_channel <= s_axis_tdata[3:0];
      s1_sample  <= s_axis_tdata[15:4];
    end
  end

  // Decode the request and work out the next bank state
  always_comb begin
    white_done_next = white_done;
    cal_next        = cal;
    active_next[0]  = active[0];
    active_next[1]  = active[1];
    status_next     = lsc_pkg::STATUS_OK;
    bank_cmd[0]     = '0;
    bank_cmd[1]     = '0;
    if (adv) begin
      unique case (lsc_pkg::req_t'(s1_req)) inside
        lsc_pkg::REQ_WHITE, lsc_pkg::REQ_GREEN: begin
          bank_cmd[s1_side].accum = 1'b1;
        end
        lsc_pkg::REQ_END_WHITE: begin
          bank_cmd[s1_side].end_white = 1'b1;
          white_done_next[s1_side]    = 1'b1;
          cal_next[s1_side]           = 1'b0;
        end
        lsc_pkg::REQ_END_GREEN: begin
          if (!white_done[s1_side]) begin
            status_next = lsc_pkg::STATUS_NO_WHITE;
          end else begin
            bank_cmd[s1_side].end_green = 1'b1;
            cal_next[s1_side]           = 1'b1;
          end
        end
        lsc_pkg::REQ_CLASSIFY: begin
          if (!(cal[0] && cal[1])) begin
            status_next = lsc_pkg::STATUS_NOT_CAL;
          end else if (bank_res[s1_side].in_range) begin
            active_next[s1_side][s1_channel] = bank_res[s1_side].active;
          end
        end
        default: begin
          // unknown kinds: drop, status ok
        end
      endcase
    end
  end

  // Sensor banks, 0 right and 1 left
  for (genvar s = 0; s < 2; s++) begin : g_bank
    lsc_bank #(
      .CHANNELS        (CHANNELS),
      .CAL_SAMPLES_LOG2(CAL_SAMPLES_LOG2),
      .SAMPLE_BITS     (SAMPLE_BITS)
    ) u_bank (
      .clk       (clk),
      .rst       (rst),
      .cmd       (bank_cmd[s]),
      .channel   (s1_channel),
      .sample_val(sample_val),
      .res       (bank_res[s])
    );
  end

  // Update bank flags and active bits
  always_ff @(posedge clk) begin
    if (rst) begin
      white_done <= '0;
      cal        <= '0;
      active[0]  <= '0;
      active[1]  <= '0;
    end else begin
      white_done <= white_done_next;
      cal        <= cal_next;
      active[0]  <= active_next[0];
      active[1]  <= active_next[1];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_axis_tuser <= status_next;
      m_axis_tdata <= {6'b0, cal_next[1], cal_next[0], active_next[1], active_next[0]};
    end
  end

`ifndef SYNTHESIS
  // A calibrated bank always has its white level captured
  a_cal_needs_white: assert property (@(posedge clk) disable iff (rst)
    (cal[0] |-> white_done[0]) and (cal[1] |-> white_done[1]))
    else $error("bank calibrated without white capture");

  // Input stalls only while the input register holds an item
  a_stall_has_item: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> s1_valid)
    else $error("input stalled with empty input register");

  // A rejected end-green leaves the calibrated flags alone
  a_no_white_keeps_cal: assert property (@(posedge clk) disable iff (rst)
    (adv && status_next == lsc_pkg::STATUS_NO_WHITE) |=> $stable(cal))
    else $error("calibrated flags changed on rejected end green");

  // A classify refused for lack of calibration reports at least one flag not set
  a_not_cal_flags: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == lsc_pkg::STATUS_NOT_CAL)
      |-> !(m_axis_tdata[32] && m_axis_tdata[33]))
    else $error("not-calibrated status with both banks ready");
`endif

endmodule
